[rtl/core/etmm_pkg.sv]
package etmm_pkg;

   localparam int VAL_W = 32;
   localparam int GID_W = 24;

   // Store depths; the request port widths are sized for these.
   localparam int MAX_SHAPES = 8;
   localparam int MAX_NODES  = 16;

   typedef enum logic [1:0] {
      OP_LOAD_NODE  = 2'd0,
      OP_LOAD_TEST  = 2'd1,
      OP_LOAD_TRIAL = 2'd2,
      OP_COMPUTE    = 2'd3
   } opcode_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RD,
      ST_MUL_JW,
      ST_MUL_SC,
      ST_TV0,
      ST_TV1,
      ST_TU0,
      ST_TU1,
      ST_MUL_T,
      ST_MUL_TU,
      ST_EMIT
   } state_type;

   // Requests to the shared multiplier
   typedef struct packed {
      logic signed [VAL_W-1:0] op_a;
      logic signed [VAL_W-1:0] op_b;
   } mul_req_type;

   function automatic logic signed [VAL_W-1:0] sat32(input logic signed [65:0] x);
      logic signed [65:0] max_v;
      logic signed [65:0] min_v;
      max_v = 66'sh0_7FFF_FFFF;
      min_v = -66'sh0_8000_0000;
      if (x > max_v) begin
         sat32 = 32'sh7FFF_FFFF;
      end else if (x < min_v) begin
         sat32 = 32'sh8000_0000;
      end else begin
         sat32 = x[VAL_W-1:0];
      end
   endfunction

endpackage

[rtl/core/etmm_ram.sv]
module etmm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end
   assign rd_data = rd_data_ff;
endmodule

[rtl/core/etmm_mul.sv]
// Shared 32x32 signed multiplier, registered product.
module etmm_mul
   import etmm_pkg::*;
(
   input  logic                clock,
   input  mul_req_type         req,
   output logic signed [63:0]  prod
);
   logic signed [63:0] prod_ff;
   logic signed [63:0] prod_in;

   assign prod_in = 64'(req.op_a) * 64'(req.op_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end
   assign prod = prod_ff;
endmodule

[rtl/core/element_tangential_mass_matrix_top.sv]
// Tangential-trace mass matrix of one mesh element, Q16.16 fixed point.
// Request channel: start/busy command style. A request is taken on a clock
// edge with start high and busy low. opcode 0 loads one quadrature node
// (jacobian, weight, coefficient, nx, ny), 1/2 load a test/trial shape value
// pair for (dof, node) and its global index, 3 computes the element.
// Loads never raise busy.
// Compute walks test i (outer), trial j (inner), node k (innermost) with one
// shared 32x32 multiplier. Each node takes a memory read, eight multiplies
// through the registered multiplier and an accumulate. busy stays high from
// the accepting edge until the walk ends. An entry shows the cycle after its
// last node; the final entry shows in the first cycle with busy low, when
// the next request can be taken. Nodes with non-positive weight still walk
// the sequence but add nothing. Each result shows on rsp_* for one cycle
// with rsp_valid high; the receiver cannot stall, so results simply stream
// out. rsp_last_entry marks the final result. With req_area_positive low a
// single zero_area warning is given: busy for one cycle, the warning on the
// ports in the cycle after. csr_wr_en/csr_wr_data set node_count (reset 4),
// to be written by the user only while idle; the block does not check it.
// Reset (synchronous, active high) clears the sequencer; the node and shape
// stores are not cleared and must be loaded before use.
module element_tangential_mass_matrix_top
   import etmm_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [1:0]              req_opcode,
   input  logic [3:0]              req_node_index,
   input  logic [2:0]              req_dof_index,
   input  logic signed [31:0]      req_value_a,
   input  logic signed [31:0]      req_value_b,
   input  logic signed [31:0]      req_value_c,
   input  logic signed [31:0]      req_value_d,
   input  logic signed [31:0]      req_value_e,
   input  logic [23:0]             req_global_index,
   input  logic                    req_area_positive,
   input  logic [3:0]              req_test_count,
   input  logic [3:0]              req_trial_count,
   output logic                    rsp_valid,
   output logic [23:0]             rsp_row_index,
   output logic [23:0]             rsp_col_index,
   output logic signed [31:0]      rsp_entry_value,
   output logic                    rsp_zero_area,
   output logic                    rsp_last_entry,
   input  logic                    csr_wr_en,
   input  logic [4:0]              csr_wr_data
);
   localparam int NW  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int SW  = (MAX_SHAPES > 1) ? $clog2(MAX_SHAPES) : 1;
   localparam int SHW = NW + SW;
   localparam int NCW = $clog2(MAX_NODES + 1);
   localparam int SCW = $clog2(MAX_SHAPES + 1);

   logic       accept;
   opcode_type op;
   assign op     = opcode_type'(req_opcode);
   assign accept = start && !busy;

   logic       node_ok, dof_ok;
   assign node_ok = 32'(req_node_index) < MAX_NODES;
   assign dof_ok  = 32'(req_dof_index) < MAX_SHAPES;

   // node_count register
   logic [4:0] node_count_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= 5'd4;
      end else if (csr_wr_en) begin
         node_count_ff <= csr_wr_data;
      end
   end

   // sequencer state
   state_type          state_ff, state_in;
   logic [SCW-1:0]     ntest_ff, ntest_in, ntrial_ff, ntrial_in;
   logic [NCW-1:0]     nn_ff, nn_in;
   logic [SW-1:0]      i_ff, i_in, j_ff, j_in;
   logic [NW-1:0]      k_ff, k_in;
   logic signed [63:0] acc_ff, acc_in;
   logic signed [31:0] s_ff, s_in, t_ff, t_in, vx_ff, vx_in;
   logic signed [63:0] d_ff, d_in;
   logic               wpos_ff, wpos_in;
   logic               warn_ff, warn_in;

   // stores
   logic [NW-1:0]  node_wa, node_ra;
   logic [31:0]    jac_q, wgt_q, coef_q;
   logic [63:0]    nrm_q;
   logic           node_we;
   assign node_we = accept && op == OP_LOAD_NODE && node_ok;
   assign node_wa = req_node_index[NW-1:0];
   assign node_ra = k_ff;

   etmm_ram #(.WIDTH(32), .DEPTH(MAX_NODES)) u_jac (.clock, .wr_en(node_we),
      .wr_addr(node_wa), .wr_data(req_value_a), .rd_addr(node_ra), .rd_data(jac_q));
   etmm_ram #(.WIDTH(32), .DEPTH(MAX_NODES)) u_wgt (.clock, .wr_en(node_we),
      .wr_addr(node_wa), .wr_data(req_value_b), .rd_addr(node_ra), .rd_data(wgt_q));
   etmm_ram #(.WIDTH(32), .DEPTH(MAX_NODES)) u_coef (.clock, .wr_en(node_we),
      .wr_addr(node_wa), .wr_data(req_value_c), .rd_addr(node_ra), .rd_data(coef_q));
   etmm_ram #(.WIDTH(64), .DEPTH(MAX_NODES)) u_nrm (.clock, .wr_en(node_we),
      .wr_addr(node_wa), .wr_data({req_value_e, req_value_d}), .rd_addr(node_ra),
      .rd_data(nrm_q));

   logic           test_we, trial_we;
   logic [SHW-1:0] shp_wa, test_ra, trial_ra;
   logic [63:0]    test_q, trial_q;
   logic [23:0]    test_gid_q, trial_gid_q;
   assign test_we  = accept && op == OP_LOAD_TEST && node_ok && dof_ok;
   assign trial_we = accept && op == OP_LOAD_TRIAL && node_ok && dof_ok;
   assign shp_wa   = {req_dof_index[SW-1:0], req_node_index[NW-1:0]};
   assign test_ra  = {i_ff, k_ff};
   assign trial_ra = {j_ff, k_ff};

   etmm_ram #(.WIDTH(64), .DEPTH(MAX_SHAPES*MAX_NODES)) u_tst (.clock,
      .wr_en(test_we), .wr_addr(shp_wa), .wr_data({req_value_b, req_value_a}),
      .rd_addr(test_ra), .rd_data(test_q));
   etmm_ram #(.WIDTH(64), .DEPTH(MAX_SHAPES*MAX_NODES)) u_trl (.clock,
      .wr_en(trial_we), .wr_addr(shp_wa), .wr_data({req_value_b, req_value_a}),
      .rd_addr(trial_ra), .rd_data(trial_q));
   etmm_ram #(.WIDTH(24), .DEPTH(MAX_SHAPES)) u_tgid (.clock, .wr_en(test_we),
      .wr_addr(req_dof_index[SW-1:0]), .wr_data(req_global_index),
      .rd_addr(i_ff), .rd_data(test_gid_q));
   etmm_ram #(.WIDTH(24), .DEPTH(MAX_SHAPES)) u_rgid (.clock, .wr_en(trial_we),
      .wr_addr(req_dof_index[SW-1:0]), .wr_data(req_global_index),
      .rd_addr(j_ff), .rd_data(trial_gid_q));

   // shared multiplier
   mul_req_type        mreq;
   logic signed [63:0] prod;
   etmm_mul u_mul (.clock, .req(mreq), .prod);

   // floor shift then saturate
   logic signed [31:0] prod_q;
   logic signed [63:0] prod_sh;
   logic signed [31:0] d_q;
   assign prod_sh = prod >>> 16;
   assign prod_q  = sat32(66'(prod_sh));
   assign d_q     = sat32(66'((66'(d_ff) - 66'(prod)) >>> 16));

   logic [3:0] ntest_sat, ntrial_sat;
   logic [4:0] nn_sat;
   assign ntest_sat  = (32'(req_test_count) > MAX_SHAPES) ? 4'(MAX_SHAPES) : req_test_count;
   assign ntrial_sat = (32'(req_trial_count) > MAX_SHAPES) ? 4'(MAX_SHAPES) :
                       req_trial_count;
   assign nn_sat     = (32'(node_count_ff) > MAX_NODES) ? 5'(MAX_NODES) : node_count_ff;

   logic last_k, last_j, last_i;
   assign last_k = 32'(k_ff) + 1 >= 32'(nn_ff);
   assign last_j = 32'(j_ff) + 1 >= 32'(ntrial_ff);
   assign last_i = 32'(i_ff) + 1 >= 32'(ntest_ff);

   always_comb begin
      state_in  = state_ff;
      ntest_in  = ntest_ff;
      ntrial_in = ntrial_ff;
      nn_in     = nn_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      k_in      = k_ff;
      acc_in    = acc_ff;
      s_in      = s_ff;
      t_in      = t_ff;
      vx_in     = vx_ff;
      d_in      = d_ff;
      wpos_in   = wpos_ff;
      warn_in   = 1'b0;
      mreq      = '{op_a: jac_q, op_b: wgt_q};
      case (state_ff)
         ST_IDLE: begin
            if (accept && op == OP_COMPUTE) begin
               i_in = '0; j_in = '0; k_in = '0; acc_in = '0;
               ntest_in  = SCW'(ntest_sat);
               ntrial_in = SCW'(ntrial_sat);
               nn_in     = NCW'(nn_sat);
               if (!req_area_positive) begin
                  warn_in = 1'b1;
               end else if (ntest_sat != 4'd0 && ntrial_sat != 4'd0) begin
                  state_in = ST_RD;
               end
            end
         end
         // global index read lands by EMIT even with no nodes
         ST_RD: state_in = (nn_ff == '0) ? ST_EMIT : ST_MUL_JW;
         ST_MUL_JW: begin
            // issue jac*w; capture weight sign
            mreq     = '{op_a: jac_q, op_b: wgt_q};
            wpos_in  = !wgt_q[31] && wgt_q != 32'd0;
            state_in = ST_MUL_SC;
         end
         ST_MUL_SC: begin
            mreq     = '{op_a: prod_q, op_b: coef_q};
            state_in = ST_TV0;
         end
         ST_TV0: begin
            s_in     = prod_q;
            mreq     = '{op_a: test_q[31:0], op_b: nrm_q[63:32]};
            state_in = ST_TV1;
         end
         ST_TV1: begin
            d_in     = prod;
            mreq     = '{op_a: test_q[63:32], op_b: nrm_q[31:0]};
            state_in = ST_TU0;
         end
         ST_TU0: begin
            vx_in    = d_q;
            mreq     = '{op_a: trial_q[31:0], op_b: nrm_q[63:32]};
            state_in = ST_TU1;
         end
         ST_TU1: begin
            d_in     = prod;
            mreq     = '{op_a: trial_q[63:32], op_b: nrm_q[31:0]};
            state_in = ST_MUL_T;
         end
         ST_MUL_T: begin
            vx_in    = d_q; // ux now
            t_in     = vx_ff;
            mreq     = '{op_a: s_ff, op_b: vx_ff};
            state_in = ST_MUL_TU;
         end
         ST_MUL_TU: begin
            t_in     = prod_q;
            mreq     = '{op_a: prod_q, op_b: vx_ff};
            state_in = ST_EMIT;
            s_in     = s_ff;
            d_in     = 64'sd0;
         end
         ST_EMIT: begin
            // accumulate last node term (if any) then step
            if (nn_ff != '0 && wpos_ff) begin
               acc_in = acc_ff + prod_sh;
            end
            if (nn_ff != '0 && !last_k) begin
               k_in = k_ff + 1'b1;
               state_in = ST_RD;
            end else begin
               k_in   = '0;
               acc_in = '0;
               if (!last_j) begin
                  j_in = j_ff + 1'b1;
                  state_in = ST_RD;
               end else if (!last_i) begin
                  j_in = '0;
                  i_in = i_ff + 1'b1;
                  state_in = ST_RD;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         warn_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         warn_ff  <= warn_in;
      end
      ntest_ff  <= ntest_in;
      ntrial_ff <= ntrial_in;
      nn_ff     <= nn_in;
      i_ff      <= i_in;
      j_ff      <= j_in;
      k_ff      <= k_in;
      acc_ff    <= acc_in;
      s_ff      <= s_in;
      t_ff      <= t_in;
      vx_ff     <= vx_in;
      d_ff      <= d_in;
      wpos_ff   <= wpos_in;
   end

   // result: formed in EMIT at the last node, registered for one cycle
   logic               emit;
   logic signed [63:0] sum_fin;
   assign emit    = state_ff == ST_EMIT && (nn_ff == '0 || last_k);
   assign sum_fin = (nn_ff != '0 && wpos_ff) ? acc_ff + prod_sh : acc_ff;

   logic               rv_ff;
   logic [23:0]        row_ff, col_ff;
   logic signed [31:0] ev_ff;
   logic               za_ff, le_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff <= 1'b0;
      end else begin
         rv_ff <= emit || warn_ff;
      end
      row_ff <= warn_ff ? 24'd0 : test_gid_q;
      col_ff <= warn_ff ? 24'd0 : trial_gid_q;
      ev_ff  <= warn_ff ? 32'sd0 : sat32(66'(sum_fin));
      za_ff  <= warn_ff;
      le_ff  <= warn_ff || (last_i && last_j);
   end

   // busy covers the warning cycle and the compute walk
   assign busy            = state_ff != ST_IDLE || warn_ff;
   assign rsp_valid       = rv_ff;
   assign rsp_row_index   = row_ff;
   assign rsp_col_index   = col_ff;
   assign rsp_entry_value = ev_ff;
   assign rsp_zero_area   = za_ff;
   assign rsp_last_entry  = le_ff;

`ifndef SYNTHESIS
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> busy) else $error("busy low during compute");
   a_warn_result: assert property (@(posedge clock) disable iff (reset)
      warn_ff |=> rsp_valid && rsp_zero_area && rsp_last_entry)
      else $error("warning result missing");
   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_entry && !rsp_zero_area |-> state_ff == ST_IDLE)
      else $error("walk continues after last entry");
`endif
endmodule
